// ===== rtl/hpp_pkg.sv =====
// ----------------------------------------------------------------------------
// hpp_pkg
// Shared constants and types for the Hilbert pixel placer.
// ----------------------------------------------------------------------------
package hpp_pkg;

  localparam int unsigned IDX_W       = 20;  // curve index field
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned COLOR_W     = 3 * BYTE_W;
  localparam int unsigned COORD_W     = 10;  // col / row fields
  localparam int unsigned POWER_W     = 4;
  localparam int unsigned ADDR_W      = 32;
  localparam int unsigned SUM_W       = ADDR_W + 2;  // bound sum never wraps
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned DEF_MAX_POWER = 10;
  localparam int unsigned BYTE_TAIL   = 3;   // last byte of a four-byte group

  localparam logic [POWER_W-1:0] POWER_RST = POWER_W'(8);
  localparam logic [ADDR_W-1:0]  START_RST = '0;
  localparam logic [ADDR_W-1:0]  BYTES_RST = '0;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POWER = 2'd0,
    REG_START = 2'd1,
    REG_BYTES = 2'd2
  } cfg_reg_e;

endpackage

// ===== rtl/hpp_front.sv =====
// ----------------------------------------------------------------------------
// hpp_front
// Input stage: masks the index to the active curve size, runs the map bound
// check and forms the packed color.
// ----------------------------------------------------------------------------
module hpp_front #(
  parameter int unsigned PW = 4
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [PW-1:0]                eff_power_i,
  input  logic [hpp_pkg::ADDR_W-1:0]   start_i,
  input  logic [hpp_pkg::ADDR_W-1:0]   bytes_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [hpp_pkg::IDX_W-1:0]    index_i,
  input  logic [hpp_pkg::BYTE_W-1:0]   red_i,
  input  logic [hpp_pkg::BYTE_W-1:0]   green_i,
  input  logic [hpp_pkg::BYTE_W-1:0]   blue_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [hpp_pkg::IDX_W-1:0]    index_o,
  output logic [hpp_pkg::COLOR_W-1:0]  color_o,
  output logic                         inside_o
);
  import hpp_pkg::*;

  logic                v_q;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [COLOR_W-1:0]  color_q, color_d;
  logic                inside_q, inside_d;
  logic [SUM_W-1:0]    last_byte;

  always_comb begin
    for (int b = 0; b < int'(IDX_W); b++) begin
      idx_d[b] = index_i[b] & (b < 2 * int'(eff_power_i));
    end
    last_byte = {2'b00, start_i[ADDR_W-1:2], 2'b00}
              + SUM_W'({idx_d, 2'b00})
              + SUM_W'(BYTE_TAIL);
    inside_d  = last_byte < {2'b00, bytes_i};
    color_d   = inside_d ? {red_i, green_i, blue_i} : '0;
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      idx_q    <= idx_d;
      color_q  <= color_d;
      inside_q <= inside_d;
    end
  end

  assign valid_o  = v_q;
  assign index_o  = idx_q;
  assign color_o  = color_q;
  assign inside_o = inside_q;

`ifndef SYNTHESIS
  // pixels outside the map carry no color
  a_black_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !inside_q |-> color_q == '0)
    else $error("outside pixel carries color");
`endif

endmodule

// ===== rtl/hpp_cell.sv =====
// ----------------------------------------------------------------------------
// hpp_cell
// One curve level: consumes two index bits; if active, rotates/reflects the
// partial point inside its quadrant and moves it into the chosen quadrant.
// ----------------------------------------------------------------------------
module hpp_cell #(
  parameter int unsigned LEVEL = 0,
  parameter int unsigned C     = 10,
  parameter int unsigned PW    = 4,
  parameter int unsigned TW    = 20
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [PW-1:0]                eff_power_i,
  input  logic                         valid_i,
  output logic                         ready_o,
  input  logic [TW-1:0]                t_i,
  input  logic [C-1:0]                 x_i,
  input  logic [C-1:0]                 y_i,
  input  logic [hpp_pkg::COLOR_W-1:0]  color_i,
  input  logic                         inside_i,
  output logic                         valid_o,
  input  logic                         ready_i,
  output logic [TW-1:0]                t_o,
  output logic [C-1:0]                 x_o,
  output logic [C-1:0]                 y_o,
  output logic [hpp_pkg::COLOR_W-1:0]  color_o,
  output logic                         inside_o
);
  import hpp_pkg::*;

  // side - 1 - v equals v ^ (side - 1) since v < side
  localparam logic [C-1:0] LOW_MASK = C'((64'd1 << LEVEL) - 64'd1);

  logic                v_q;
  logic [TW-1:0]       t_q;
  logic [C-1:0]        x_q, x_d, y_q, y_d;
  logic [COLOR_W-1:0]  color_q;
  logic                inside_q;
  logic                active, qx, qy;
  logic [C-1:0]        xr, yr;

  always_comb begin
    active = int'(eff_power_i) > int'(LEVEL);
    qx     = t_i[1];
    qy     = t_i[0] ^ t_i[1];
    xr     = qx ? (x_i ^ LOW_MASK) : x_i;
    yr     = qx ? (y_i ^ LOW_MASK) : y_i;
    x_d    = x_i;
    y_d    = y_i;
    if (active) begin
      if (!qy) begin
        x_d = yr;
        y_d = xr;
      end
      x_d[LEVEL] = qx;
      y_d[LEVEL] = qy;
    end
  end

  assign ready_o = !v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (ready_o) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      t_q      <= t_i >> 2;
      x_q      <= x_d;
      y_q      <= y_d;
      color_q  <= color_i;
      inside_q <= inside_i;
    end
  end

  assign valid_o  = v_q;
  assign t_o      = t_q;
  assign x_o      = x_q;
  assign y_o      = y_q;
  assign color_o  = color_q;
  assign inside_o = inside_q;

`ifndef SYNTHESIS
  // point stays inside the square built so far
  a_point_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q |-> ((x_q >> (LEVEL + 1)) == '0) && ((y_q >> (LEVEL + 1)) == '0))
    else $error("point outside level square");

  a_hold_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v_q && !ready_i |=> v_q && $stable(x_q) && $stable(y_q) && $stable(color_q))
    else $error("held point changed");
`endif

endmodule

// ===== rtl/hilbert_pixel_placer_core.sv =====
// ----------------------------------------------------------------------------
// hilbert_pixel_placer_core
// Places one pixel of a byte map on a Hilbert curve (index to col/row).
// ----------------------------------------------------------------------------
// One pixel per clock in a steady stream while out_stall_i is low. Each transfer
// runs through an input stage (index mask, map bound check, color packing) and
// then a chain of MAX_POWER level cells, one curve level per cell. The last cell
// register drives the outputs; an empty cell anywhere in the chain lets a new
// pixel in while a finished one is held by out_stall_i. Registers are written
// through the cfg port and must only change while the pipeline is empty.
module hilbert_pixel_placer_core #(
  parameter int unsigned MAX_POWER = hpp_pkg::DEF_MAX_POWER
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [hpp_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [hpp_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [hpp_pkg::IDX_W-1:0]       curve_index_i,
  input  logic [hpp_pkg::BYTE_W-1:0]      red_byte_i,
  input  logic [hpp_pkg::BYTE_W-1:0]      green_byte_i,
  input  logic [hpp_pkg::BYTE_W-1:0]      blue_byte_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [hpp_pkg::COORD_W-1:0]     col_o,
  output logic [hpp_pkg::COORD_W-1:0]     row_o,
  output logic [hpp_pkg::COLOR_W-1:0]     pixel_color_o,
  output logic                            inside_map_o
);
  import hpp_pkg::*;

  localparam int unsigned PW = $clog2(MAX_POWER + 1);
  localparam int unsigned TW = (2 * MAX_POWER > IDX_W) ? 2 * MAX_POWER : IDX_W;
  localparam int unsigned C  = MAX_POWER;

  logic [POWER_W-1:0] power_q;
  logic [ADDR_W-1:0]  start_q, bytes_q;
  logic [PW-1:0]      eff_power;

  // register write
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_q <= POWER_RST;
      start_q <= START_RST;
      bytes_q <= BYTES_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        REG_POWER: power_q <= cfg_data_i[POWER_W-1:0];
        REG_START: start_q <= cfg_data_i[ADDR_W-1:0];
        REG_BYTES: bytes_q <= cfg_data_i[ADDR_W-1:0];
        default:   ;
      endcase
    end
  end

  always_comb begin
    if (power_q == '0) begin
      eff_power = PW'(1);
    end else if (int'(power_q) > int'(MAX_POWER)) begin
      eff_power = PW'(MAX_POWER);
    end else begin
      eff_power = PW'(power_q);
    end
  end

  // stage k feeds cell k; stage MAX_POWER is the output
  logic [MAX_POWER:0]               st_v, st_rdy, st_in;
  logic [MAX_POWER:0][TW-1:0]       st_t;
  logic [MAX_POWER:0][C-1:0]        st_x, st_y;
  logic [MAX_POWER:0][COLOR_W-1:0]  st_color;
  logic [IDX_W-1:0]                 front_idx;
  logic                             front_rdy;

  hpp_front #(
    .PW (PW)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .eff_power_i (eff_power),
    .start_i     (start_q),
    .bytes_i     (bytes_q),
    .valid_i     (in_valid_i),
    .ready_o     (front_rdy),
    .index_i     (curve_index_i),
    .red_i       (red_byte_i),
    .green_i     (green_byte_i),
    .blue_i      (blue_byte_i),
    .valid_o     (st_v[0]),
    .ready_i     (st_rdy[0]),
    .index_o     (front_idx),
    .color_o     (st_color[0]),
    .inside_o    (st_in[0])
  );

  assign in_stall_o = !front_rdy;
  assign st_t[0]    = TW'(front_idx);
  assign st_x[0]    = '0;
  assign st_y[0]    = '0;

  for (genvar k = 0; k < MAX_POWER; k++) begin : g_cell
    hpp_cell #(
      .LEVEL (k),
      .C     (C),
      .PW    (PW),
      .TW    (TW)
    ) u_cell (
      .clk_i       (clk_i),
      .rst_ni      (rst_ni),
      .eff_power_i (eff_power),
      .valid_i     (st_v[k]),
      .ready_o     (st_rdy[k]),
      .t_i         (st_t[k]),
      .x_i         (st_x[k]),
      .y_i         (st_y[k]),
      .color_i     (st_color[k]),
      .inside_i    (st_in[k]),
      .valid_o     (st_v[k+1]),
      .ready_i     (st_rdy[k+1]),
      .t_o         (st_t[k+1]),
      .x_o         (st_x[k+1]),
      .y_o         (st_y[k+1]),
      .color_o     (st_color[k+1]),
      .inside_o    (st_in[k+1])
    );
  end

  assign st_rdy[MAX_POWER] = !out_stall_i;
  assign out_valid_o       = st_v[MAX_POWER];
  assign col_o             = COORD_W'(st_x[MAX_POWER]);
  assign row_o             = COORD_W'(st_y[MAX_POWER]);
  assign pixel_color_o     = st_color[MAX_POWER];
  assign inside_map_o      = st_in[MAX_POWER];

`ifndef SYNTHESIS
  // an empty output register frees the whole chain
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled with empty output");

  // input backs up only when the chain is full and the output is held
  a_stall_needs_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> out_valid_o && out_stall_i && (&st_v))
    else $error("input stalled without back pressure");
`endif

endmodule

// ===== verif/tb_hilbert_pixel_placer_core.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hilbert_pixel_placer_core
// Self-checking bench: a short table of corner pixels, then random pixels under
// changing curve power and map bounds, with sender gaps and receiver stalls.
// Every result is checked against a table entry or a local curve/bound model.
// ----------------------------------------------------------------------------
module tb_hilbert_pixel_placer_core;
  import hpp_pkg::*;

  localparam int unsigned MAX_POWER = DEF_MAX_POWER;
  localparam int unsigned WATCHDOG  = 5000;
  localparam int unsigned SEGMENTS  = 12;
  localparam int unsigned SEG_ITEMS = 104;
  localparam int unsigned PLAN_LEN  = 25;
  localparam int unsigned MAX_SHOWN = 10;

  // index past the register list, writes to it must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd3;

  typedef struct packed {
    logic [IDX_W-1:0]  index;
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } pixel_in_t;

  typedef struct packed {
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
    logic [COLOR_W-1:0] color;
    logic               in_map;
  } pixel_out_t;

  typedef enum logic [1:0] {ROW_PIXEL, ROW_SETUP, ROW_BADREG} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [31:0] arg;    // curve index, power data, or raw write data
    logic [31:0] start;
    logic [31:0] bytes;
    logic [23:0] rgb;
    bit          typed;
    pixel_out_t  want;
  } plan_row_t;

  plan_row_t plan [PLAN_LEN] = '{
    // reset registers: 8 levels, empty map
    '{ROW_PIXEL,  32'h00000, 0, 0, 24'hffffff, 1'b1, '{10'd0,    10'd0, 24'h0, 1'b0}},
    '{ROW_PIXEL,  32'hfffff, 0, 0, 24'h000000, 1'b1, '{10'd255,  10'd0, 24'h0, 1'b0}},
    '{ROW_SETUP,  32'd1, 0, 32'hffffffff, 0, 1'b0, '0},
    '{ROW_PIXEL,  32'h00000, 0, 0, 24'h123456, 1'b1, '{10'd0, 10'd0, 24'h123456, 1'b1}},
    '{ROW_PIXEL,  32'h00001, 0, 0, 24'h00ff00, 1'b1, '{10'd0, 10'd1, 24'h00ff00, 1'b1}},
    '{ROW_PIXEL,  32'h00002, 0, 0, 24'hff0000, 1'b1, '{10'd1, 10'd1, 24'hff0000, 1'b1}},
    '{ROW_PIXEL,  32'h00003, 0, 0, 24'h0000ff, 1'b1, '{10'd1, 10'd0, 24'h0000ff, 1'b1}},
    // high index bits dropped
    '{ROW_PIXEL,  32'hfffff, 0, 0, 24'ha5a5a5, 1'b1, '{10'd1, 10'd0, 24'ha5a5a5, 1'b1}},
    // power 0 behaves as 1
    '{ROW_SETUP,  32'd0, 0, 32'hffffffff, 0, 1'b0, '0},
    '{ROW_PIXEL,  32'h00002, 0, 0, 24'h5a5a5a, 1'b1, '{10'd1, 10'd1, 24'h5a5a5a, 1'b1}},
    // power 15 clamps to the deepest curve
    '{ROW_SETUP,  32'd15, 0, 32'hffffffff, 0, 1'b0, '0},
    '{ROW_PIXEL,  32'hfffff, 0, 0, 24'hffffff, 1'b1, '{10'd1023, 10'd0, 24'hffffff, 1'b1}},
    '{ROW_PIXEL,  32'h55555, 0, 0, 24'h3c3c3c, 1'b0, '0},
    // start low bits cleared, map ends on the last byte of index 5
    '{ROW_SETUP,  32'd10, 32'd7, 32'd28, 0, 1'b0, '0},
    '{ROW_PIXEL,  32'h00005, 0, 0, 24'h112233, 1'b0, '0},
    '{ROW_PIXEL,  32'h00006, 0, 0, 24'h445566, 1'b0, '0},
    '{ROW_PIXEL,  32'h00004, 0, 0, 24'h778899, 1'b0, '0},
    // bound sum runs past 32 bits
    '{ROW_SETUP,  32'd10, 32'hffffffff, 32'hffffffff, 0, 1'b0, '0},
    '{ROW_PIXEL,  32'h00000, 0, 0, 24'hffffff, 1'b1, '{10'd0, 10'd0, 24'h0, 1'b0}},
    '{ROW_PIXEL,  32'haaaaa, 0, 0, 24'h00ffff, 1'b0, '0},
    '{ROW_BADREG, 32'h1, 0, 0, 0, 1'b0, '0},
    '{ROW_PIXEL,  32'h12345, 0, 0, 24'h808080, 1'b0, '0},
    '{ROW_SETUP,  32'd10, 32'd0, 32'd4, 0, 1'b0, '0},
    '{ROW_PIXEL,  32'h00000, 0, 0, 24'h010203, 1'b1, '{10'd0, 10'd0, 24'h010203, 1'b1}},
    '{ROW_PIXEL,  32'h00001, 0, 0, 24'h040506, 1'b0, '0}
  };

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  cfg_valid   = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [CFG_DATA_W-1:0] cfg_data    = '0;
  logic                  in_valid    = 1'b0;
  logic                  in_stall;
  logic [IDX_W-1:0]      curve_index = '0;
  logic [BYTE_W-1:0]     red_byte    = '0;
  logic [BYTE_W-1:0]     green_byte  = '0;
  logic [BYTE_W-1:0]     blue_byte   = '0;
  logic                  out_valid;
  logic                  out_stall   = 1'b0;
  logic [COORD_W-1:0]    col;
  logic [COORD_W-1:0]    row;
  logic [COLOR_W-1:0]    pixel_color;
  logic                  inside_map;

  // register copies seen by the predictor
  logic [POWER_W-1:0] shadow_power = POWER_RST;
  logic [ADDR_W-1:0]  shadow_start = START_RST;
  logic [ADDR_W-1:0]  shadow_bytes = BYTES_RST;

  pixel_out_t  pending_pixels [$];
  int unsigned gap_pct     = 0;
  int unsigned stall_pct   = 0;
  int unsigned idle_cycles = 0;
  int unsigned n_sent      = 0;
  int unsigned n_recv      = 0;
  int unsigned n_inside    = 0;
  int unsigned n_cfg       = 0;
  int unsigned n_errors    = 0;

  hilbert_pixel_placer_core #(
    .MAX_POWER(MAX_POWER)
  ) u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_index_i   (cfg_index),
    .cfg_data_i    (cfg_data),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .curve_index_i (curve_index),
    .red_byte_i    (red_byte),
    .green_byte_i  (green_byte),
    .blue_byte_i   (blue_byte),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .col_o         (col),
    .row_o         (row),
    .pixel_color_o (pixel_color),
    .inside_map_o  (inside_map)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic int unsigned clamp_power(input logic [POWER_W-1:0] p);
    if (p < 1) return 1;
    if (p > MAX_POWER) return MAX_POWER;
    return 32'(p);
  endfunction

  // index -> cell along the curve, plus map bound and color
  function automatic pixel_out_t place_pixel(input pixel_in_t px);
    int unsigned     lv, k, x, y, side, qx, qy, tmp;
    longint unsigned idx, t, last;
    pixel_out_t      res;
    lv  = clamp_power(shadow_power);
    idx = 64'(px.index);
    idx = idx & ((64'd1 << (2 * lv)) - 1);
    t = idx;
    x = 0;
    y = 0;
    for (k = 0; k < lv; k++) begin
      side = 1 << k;
      qx   = 32'((t >> 1) & 1);
      qy   = 32'((t ^ qx) & 1);
      if (qy == 0) begin
        if (qx == 1) begin
          x = side - 1 - x;
          y = side - 1 - y;
        end
        tmp = x;
        x   = y;
        y   = tmp;
      end
      x += side * qx;
      y += side * qy;
      t >>= 2;
    end
    last = {32'd0, shadow_start & ~32'd3} + 4 * idx + BYTE_TAIL;
    res.col    = COORD_W'(x);
    res.row    = COORD_W'(y);
    res.in_map = (last < {32'd0, shadow_bytes});
    res.color  = res.in_map ? {px.red, px.green, px.blue} : '0;
    return res;
  endfunction

  task automatic push_pixel(input pixel_in_t px, input bit typed, input pixel_out_t want);
    while ($urandom_range(99) < gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid    <= 1'b1;
    curve_index <= px.index;
    red_byte    <= px.red;
    green_byte  <= px.green;
    blue_byte   <= px.blue;
    @(posedge clk_i);
    while (in_stall) @(posedge clk_i);
    pending_pixels.push_back(typed ? want : place_pixel(px));
    n_sent++;
  endtask

  task automatic drain_pipe();
    in_valid <= 1'b0;
    @(posedge clk_i);
    while (pending_pixels.size() != 0) @(posedge clk_i);
  endtask

  // more = 1 keeps valid up for a back-to-back write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data, input bit more);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk_i);
    while (!cfg_ready) @(posedge clk_i);
    case (idx)
      REG_POWER: shadow_power = data[POWER_W-1:0];
      REG_START: shadow_start = data;
      REG_BYTES: shadow_bytes = data;
      default: ;
    endcase
    if (!more) cfg_valid <= 1'b0;
    n_cfg++;
  endtask

  task automatic setup_map(input logic [31:0] pw, input logic [31:0] st, input logic [31:0] nb);
    write_reg(REG_POWER, pw, 1'b1);
    write_reg(REG_START, st, 1'b1);
    write_reg(REG_BYTES, nb, 1'b0);
  endtask

  always @(posedge clk_i) begin
    out_stall <= ($urandom_range(99) < stall_pct);
  end

  // result checker and watchdog
  always @(posedge clk_i) begin
    pixel_out_t got, want;
    if (rst_ni) begin
      if (idle_cycles >= WATCHDOG) begin
        $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
                 idle_cycles, pending_pixels.size());
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
          idle_cycles <= 0;
        else
          idle_cycles <= idle_cycles + 1;
        if (out_valid && !out_stall) begin
          got = '{col, row, pixel_color, inside_map};
          if (pending_pixels.size() == 0) begin
            n_errors++;
            if (n_errors <= MAX_SHOWN)
              $display("unexpected pixel: col %0d row %0d color %06h in %0b",
                       got.col, got.row, got.color, got.in_map);
          end else begin
            want = pending_pixels.pop_front();
            n_recv++;
            if (want.in_map) n_inside++;
            if (got.col !== want.col || got.row !== want.row ||
                got.color !== want.color || got.in_map !== want.in_map) begin
              n_errors++;
              if (n_errors <= MAX_SHOWN)
                $display({"pixel %0d: expected col %0d row %0d color %06h in %0b,",
                          " got col %0d row %0d color %06h in %0b"},
                         n_recv - 1, want.col, want.row, want.color, want.in_map,
                         got.col, got.row, got.color, got.in_map);
            end
          end
        end
      end
    end
  end

  initial begin
    pixel_in_t   px;
    int unsigned seg, n, p, eff, mask, lim, idx;
    logic [31:0] st, nb, pw;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int unsigned i = 0; i < PLAN_LEN; i++) begin
      case (plan[i].kind)
        ROW_PIXEL: begin
          px = '{plan[i].arg[IDX_W-1:0], plan[i].rgb[23:16], plan[i].rgb[15:8],
                 plan[i].rgb[7:0]};
          push_pixel(px, plan[i].typed, plan[i].want);
        end
        ROW_SETUP: begin
          drain_pipe();
          setup_map(plan[i].arg, plan[i].start, plan[i].bytes);
        end
        default: begin
          drain_pipe();
          write_reg(REG_NONE, plan[i].arg, 1'b0);
        end
      endcase
    end

    for (seg = 0; seg < SEGMENTS; seg++) begin
      drain_pipe();
      case (seg)
        0:       p = 1;
        1:       p = MAX_POWER;
        default: p = $urandom_range(15);
      endcase
      eff  = clamp_power(POWER_W'(p));
      mask = (1 << (2 * eff)) - 1;
      lim  = $urandom_range(mask);
      case ($urandom_range(4))
        0:       st = 32'd0;
        1:       st = 32'hffffffff;
        2, 3:    st = $urandom_range(255);
        default: st = $urandom();
      endcase
      case ($urandom_range(5))
        0:       nb = 32'd0;
        1:       nb = 32'hffffffff;
        default: nb = (st & ~32'd3) + 4 * lim + $urandom_range(7);
      endcase
      // junk above the power field must be dropped
      pw = ($urandom() & ~32'hf) | p;
      setup_map(pw, st, nb);
      if ($urandom_range(3) == 0) write_reg(REG_NONE, $urandom(), 1'b0);

      case (seg % 4)
        0: begin gap_pct = 0;  stall_pct <= 0;  end
        1: begin gap_pct = 85; stall_pct <= 0;  end
        2: begin gap_pct = 0;  stall_pct <= 85; end
        default: begin gap_pct = 26; stall_pct <= 26; end
      endcase

      for (n = 0; n < SEG_ITEMS; n++) begin
        case ($urandom_range(3))
          0: idx = $urandom_range(20'hfffff);
          1: idx = ((lim + $urandom_range(4) - 2) & mask) | ($urandom() & ~mask);
          2: idx = $urandom() & mask;
          default: idx = $urandom_range(1) ? (($urandom_range(1) ? 20'hfffff : mask)) : 0;
        endcase
        px.index = IDX_W'(idx);
        {px.red, px.green, px.blue} = COLOR_W'($urandom());
        push_pixel(px, 1'b0, '0);
      end
    end

    gap_pct = 0;
    stall_pct <= 0;
    drain_pipe();
    repeat (MAX_POWER + 8) @(posedge clk_i);

    $display("covered %0d pixels (%0d inside the map) over %0d register writes,", n_sent,
             n_inside, n_cfg);
    $display("power 0..15, map bounds at the last byte, with gaps and stalls; %0d mismatches",
             n_errors);
    if (n_errors == 0 && pending_pixels.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
